>>> rtl/tlsrd_pkg.sv
// tlsrd_pkg: shared types and constants of the tls/dtls record deframer
// no dependencies; used by every rtl module and the checker

package tlsrd_pkg;

  // parse phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DROP    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;

  // header byte positions
  localparam logic [3:0] VER_LAST_POS = 4'd2;
  localparam logic [3:0] EPOCH_END    = 4'd5;
  localparam logic [3:0] TLS_LEN_AT   = 4'd3;
  localparam logic [3:0] DTLS_LEN_AT  = 4'd11;

  localparam logic [7:0]  DTLS_VER_HI     = 8'hFE;
  localparam logic [15:0] MAX_FRAG_RESET  = 16'd16384;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one queued result, header fields as held by the parser
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rec_type;
    logic [15:0] version;
    logic [15:0] epoch;
    logic [47:0] sequence_res;
    logic [15:0] length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

>>> rtl/tlsrd_if.sv
// tlsrd_in_if / tlsrd_out_if: valid/ready channels of the record deframer
// depends on tlsrd_pkg for nothing but keeps the same field widths

interface tlsrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       resync;

  modport source (output valid, output stream_byte, output resync, input ready);
  modport sink   (input valid, input stream_byte, input resync, output ready);
endinterface

interface tlsrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  rec_type;
  logic [15:0] version;
  logic        is_dtls;
  logic [15:0] epoch;
  logic [47:0] sequence_res;
  logic [15:0] length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output rec_type, output version,
                  output is_dtls, output epoch, output sequence_res, output length,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input rec_type, input version,
                  input is_dtls, input epoch, input sequence_res, input length,
                  input payload_byte, input last, output ready);
endinterface

>>> rtl/tlsrd_parser.sv
// tlsrd_parser: front end, takes stream beats, walks the header and payload
// depends on tlsrd_pkg and tlsrd_in_if; pushes results into tlsrd_queue

module tlsrd_parser (
  input  logic                clk,
  input  logic                rst_n,
  tlsrd_in_if.sink            in_ch,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  tlsrd_pkg::qstat_t   q_stat,
  output logic                q_push,
  output tlsrd_pkg::result_t  q_data
);

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [15:0] epoch_r, epoch_nxt;
  logic [47:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] max_r, max_nxt;
  logic        acc;

  assign in_ch.ready = !q_stat.full;
  assign acc = in_ch.valid && in_ch.ready;
  assign max_nxt = cfg_wr_en ? cfg_wr_data : max_r;

  always_comb begin
    logic [1:0] ph_v;
    logic [3:0] cnt_v;
    logic [3:0] len_at_v;
    logic       done_v;
    logic [7:0] b_v;

    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    type_nxt  = type_r;
    ver_nxt   = ver_r;
    epoch_nxt = epoch_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    q_push    = 1'b0;
    q_data    = '0;
    done_v    = 1'b0;
    len_at_v  = tlsrd_pkg::TLS_LEN_AT;
    b_v       = in_ch.stream_byte;
    ph_v      = in_ch.resync ? tlsrd_pkg::PH_HEADER : phase_r;
    cnt_v     = in_ch.resync ? 4'd0 : hcnt_r;

    if (acc) begin
      phase_nxt = ph_v;
      hcnt_nxt  = cnt_v;
      if (in_ch.resync) begin
        type_nxt = '0;
        rem_nxt  = '0;
      end
      case (ph_v)
        tlsrd_pkg::PH_HEADER: begin
          if (cnt_v == 4'd0) begin
            ver_nxt   = '0;
            epoch_nxt = '0;
            seq_nxt   = '0;
            len_nxt   = '0;
            type_nxt  = b_v;
          end else if (cnt_v <= tlsrd_pkg::VER_LAST_POS) begin
            ver_nxt = {ver_nxt[7:0], b_v};
          end else begin
            len_at_v = (ver_nxt[15:8] == tlsrd_pkg::DTLS_VER_HI) ?
                       tlsrd_pkg::DTLS_LEN_AT : tlsrd_pkg::TLS_LEN_AT;
            if (cnt_v < tlsrd_pkg::EPOCH_END && cnt_v < len_at_v) begin
              epoch_nxt = {epoch_nxt[7:0], b_v};
            end else if (cnt_v < len_at_v) begin
              seq_nxt = {seq_nxt[39:0], b_v};
            end else begin
              len_nxt = {len_nxt[7:0], b_v};
              done_v  = (cnt_v == len_at_v + 4'd1);
            end
          end
          hcnt_nxt = done_v ? 4'd0 : cnt_v + 4'd1;
          if (done_v) begin
            q_push = 1'b1;
            q_data.kind = tlsrd_pkg::KIND_HEADER;
            if (len_nxt > max_r) begin
              phase_nxt   = tlsrd_pkg::PH_DROP;
              q_data.kind = tlsrd_pkg::KIND_TOO_LONG;
              q_data.last = 1'b1;
            end else if (len_nxt == 16'd0) begin
              phase_nxt   = tlsrd_pkg::PH_HEADER;
              q_data.last = 1'b1;
            end else begin
              phase_nxt   = tlsrd_pkg::PH_PAYLOAD;
              rem_nxt     = len_nxt;
              q_data.last = 1'b0;
            end
          end
        end
        tlsrd_pkg::PH_PAYLOAD: begin
          rem_nxt = rem_r - 16'd1;
          q_push  = 1'b1;
          q_data.kind         = tlsrd_pkg::KIND_PAYLOAD;
          q_data.payload_byte = b_v;
          q_data.last         = (rem_nxt == 16'd0);
          if (rem_nxt == 16'd0) begin
            phase_nxt = tlsrd_pkg::PH_HEADER;
            hcnt_nxt  = 4'd0;
          end
        end
        default: begin
          // drop phase: bytes vanish until resync
        end
      endcase
      q_data.rec_type     = type_nxt;
      q_data.version      = ver_nxt;
      q_data.epoch        = epoch_nxt;
      q_data.sequence_res = seq_nxt;
      q_data.length       = len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tlsrd_pkg::PH_HEADER;
      hcnt_r  <= '0;
      max_r   <= tlsrd_pkg::MAX_FRAG_RESET;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      max_r   <= max_nxt;
    end
  end

  // held header fields are cleared on the first header byte, which loads the type
  always_ff @(posedge clk) begin
    type_r  <= type_nxt;
    ver_r   <= ver_nxt;
    epoch_r <= epoch_nxt;
    seq_r   <= seq_nxt;
    len_r   <= len_nxt;
    rem_r   <= rem_nxt;
  end

endmodule

>>> rtl/tlsrd_queue.sv
// tlsrd_queue: short result queue between parser and output stage
// depends on tlsrd_pkg (result_t, qstat_t, QDEPTH)

module tlsrd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tlsrd_pkg::result_t  wr_data,
  input  logic                pop,
  output tlsrd_pkg::result_t  rd_data,
  output tlsrd_pkg::qstat_t   stat
);

  tlsrd_pkg::result_t mem_r [tlsrd_pkg::QDEPTH];

  logic [tlsrd_pkg::QAW-1:0] wptr_r, wptr_nxt;
  logic [tlsrd_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [tlsrd_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign stat.full      = (cnt_r == (tlsrd_pkg::QAW+1)'(tlsrd_pkg::QDEPTH));
  assign stat.not_empty = (cnt_r != '0);
  assign do_push  = push && !stat.full;
  assign do_pop   = pop && stat.not_empty;
  assign wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
  assign rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
  assign rd_data  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/tlsrd_emit.sv
// tlsrd_emit: back end, formats queued results into the output register
// depends on tlsrd_pkg and tlsrd_out_if

module tlsrd_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  tlsrd_pkg::result_t  q_data,
  input  tlsrd_pkg::qstat_t   q_stat,
  output logic                q_pop,
  tlsrd_out_if.source         out_ch
);

  logic        valid_r, valid_nxt;
  logic        load;
  logic        dtls;
  logic [1:0]  kind_r;
  logic [7:0]  type_r;
  logic [15:0] ver_r;
  logic        dtls_r;
  logic [15:0] epoch_r;
  logic [47:0] seq_r;
  logic [15:0] len_r;
  logic [7:0]  pbyte_r;
  logic        last_r;

  assign load      = !valid_r || out_ch.ready;
  assign q_pop     = load && q_stat.not_empty;
  assign valid_nxt = load ? q_stat.not_empty : valid_r;
  assign dtls      = (q_data.version[15:8] == tlsrd_pkg::DTLS_VER_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // epoch and sequence read as zero on tls records
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= q_data.kind;
      type_r  <= q_data.rec_type;
      ver_r   <= q_data.version;
      dtls_r  <= dtls;
      epoch_r <= dtls ? q_data.epoch : 16'd0;
      seq_r   <= dtls ? q_data.sequence_res : 48'd0;
      len_r   <= q_data.length;
      pbyte_r <= q_data.payload_byte;
      last_r  <= q_data.last;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.rec_type     = type_r;
  assign out_ch.version      = ver_r;
  assign out_ch.is_dtls      = dtls_r;
  assign out_ch.epoch        = epoch_r;
  assign out_ch.sequence_res = seq_r;
  assign out_ch.length       = len_r;
  assign out_ch.payload_byte = pbyte_r;
  assign out_ch.last         = last_r;

endmodule

>>> rtl/tls_record_deframer_unit.sv
// tls_record_deframer_unit: top level of the tls/dtls record deframer
// depends on tlsrd_pkg, tlsrd_if, tlsrd_parser, tlsrd_queue, tlsrd_emit
//
//   channel | dir | handshake          | beat
//   in_ch   | in  | valid/ready        | stream_byte, resync
//   out_ch  | out | valid/ready        | kind, header fields, payload_byte, last
//   cfg     | in  | cfg_wr_en (no ack) | cfg_wr_data = max_fragment_length
//
// one input beat per cycle while the queue is not full; a result reaches out_ch
// by way of the parser push into a 4-deep queue, then the output register
// in_ch.ready drops only when the queue is full, i.e. out_ch has stalled
// synchronous active-low reset: header phase, empty queue, max length 16384

module tls_record_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  tlsrd_in_if.sink    in_ch,
  tlsrd_out_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  tlsrd_pkg::result_t push_data;
  tlsrd_pkg::result_t head_data;
  tlsrd_pkg::qstat_t  q_stat;
  logic               q_push;
  logic               q_pop;

  tlsrd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  tlsrd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (head_data),
    .stat    (q_stat)
  );

  tlsrd_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_data (head_data),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/tlsrd_checker.sv
// tlsrd_checker: port-level assertions for tls_record_deframer_unit
// depends on tlsrd_pkg; bound to the top level below

module tlsrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic        out_is_dtls,
  input logic [15:0] out_epoch,
  input logic [47:0] out_seq,
  input logic [7:0]  out_pbyte,
  input logic        out_last
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_tls_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_dtls |-> out_epoch == 16'd0 && out_seq == 48'd0)
    else $error("tls record carries epoch or sequence");

  a_pbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tlsrd_pkg::KIND_PAYLOAD |-> out_pbyte == 8'd0)
    else $error("payload byte set on a header result");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tlsrd_pkg::KIND_TOO_LONG |-> out_last)
    else $error("length error without last");

endmodule

bind tls_record_deframer_unit tlsrd_checker u_tlsrd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_is_dtls (out_ch.is_dtls),
  .out_epoch   (out_ch.epoch),
  .out_seq     (out_ch.sequence_res),
  .out_pbyte   (out_ch.payload_byte),
  .out_last    (out_ch.last)
);
